/* rtl/core/dtwm_pkg.sv */
// Shared constants, types and helpers for the dual template window matcher.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package dtwm_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int PIXEL_BITS = 16;
    localparam int WIN        = 5;
    localparam int LINES      = WIN - 1;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int POS_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int SIZE_W = 7;
    localparam int PAT_W  = WIN * WIN;
    localparam int OUT_W  = 6;

    localparam int MAP_W  = MAX_WIDTH - LINES;
    localparam int MAP_H  = MAX_HEIGHT - LINES;
    localparam int MAP_RW = $clog2(MAP_H);
    localparam int MAP_CW = $clog2(MAP_W);

    localparam int TDATA_IN_W  = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int TUSER_IN_W  = 1;
    localparam int TDATA_OUT_W = ((2 * OUT_W + 7) / 8) * 8;
    localparam int TUSER_OUT_W = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = PAT_W;

    localparam logic [SIZE_W-1:0] RST_SIZE    = SIZE_W'(15);
    localparam logic [PAT_W-1:0]  RST_PATTERN = PAT_W'(33084991);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_PAT_A  = 2'd2,
        CFG_PAT_B  = 2'd3
    } t_cfg_idx;

    typedef logic [PIXEL_BITS-1:0]             t_pix;
    typedef logic [COL_W-1:0]                  t_col;
    typedef logic [ROW_W-1:0]                  t_row;
    typedef logic [POS_W-1:0]                  t_pos;
    typedef logic [SIZE_W-1:0]                 t_size;
    typedef logic [PAT_W-1:0]                  t_pat;
    typedef logic [LINES-1:0][PIXEL_BITS-1:0]  t_line;
    typedef logic [WIN-1:0][PIXEL_BITS-1:0]    t_wcol;

    typedef struct packed {
        logic fire;
        logic clr_pre;
        logic clr_post;
        logic mark;
        logic look;
        t_pos tc;
        t_pos tr;
    } t_map_req;

    function automatic t_size clamp_size(input t_size v, input t_size hi);
        t_size res;
        if (v < SIZE_W'(WIN)) begin
            res = SIZE_W'(WIN);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* rtl/core/dtwm_line_buf.sv */
// Line store memory: one entry per column holding the four previous rows.
// Read-modify-write per pixel with forwarding; uses dtwm_pkg.
module dtwm_line_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_rd_en,
    input  dtwm_pkg::t_col       i_rd_col,
    input  logic                 i_wr_en,
    input  dtwm_pkg::t_col       i_wr_col,
    input  dtwm_pkg::t_pix       i_pix,
    output dtwm_pkg::t_wcol      o_col
);

    dtwm_pkg::t_line r_mem [dtwm_pkg::MAX_WIDTH];
    logic [dtwm_pkg::MAX_WIDTH-1:0] r_lv;
    dtwm_pkg::t_line r_rd_q;
    logic            r_rd_v;
    logic            r_fwd_v;
    dtwm_pkg::t_col  r_fwd_col;
    dtwm_pkg::t_line r_fwd_d;
    dtwm_pkg::t_line w_old;
    dtwm_pkg::t_line w_wr;

    always_comb begin
        if (r_fwd_v && (r_fwd_col == i_wr_col)) begin
            w_old = r_fwd_d;
        end else if (r_rd_v) begin
            w_old = r_rd_q;
        end else begin
            w_old = '0;
        end
        for (int k = 0; k < dtwm_pkg::LINES; k++) begin
            o_col[k] = w_old[k];
        end
        o_col[dtwm_pkg::LINES] = i_pix;
        for (int k = 0; k < dtwm_pkg::LINES - 1; k++) begin
            w_wr[k] = w_old[k+1];
        end
        w_wr[dtwm_pkg::LINES-1] = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_col] <= w_wr;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_col];
        end
        if (i_adv) begin
            r_fwd_col <= i_wr_col;
            r_fwd_d   <= w_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv    <= '0;
            r_rd_v  <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_lv[i_wr_col] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_v <= r_lv[i_rd_col];
            end
            if (i_adv) begin
                r_fwd_v <= i_wr_en;
            end
        end
    end

endmodule

/* rtl/core/dtwm_window.sv */
// 5x5 window registers and the parallel compare against both templates.
// Uses dtwm_pkg.
module dtwm_window (
    input  logic             i_clk,
    input  logic             i_shift,
    input  dtwm_pkg::t_wcol  i_col,
    input  dtwm_pkg::t_pat   i_pat_a,
    input  dtwm_pkg::t_pat   i_pat_b,
    output logic             o_hit_a,
    output logic             o_hit_b
);

    logic [dtwm_pkg::WIN-1:0][dtwm_pkg::WIN-1:0][dtwm_pkg::PIXEL_BITS-1:0] r_win;
    logic [dtwm_pkg::WIN-1:0][dtwm_pkg::WIN-1:0][dtwm_pkg::PIXEL_BITS-1:0] n_win;
    logic [dtwm_pkg::PAT_W-1:0] w_eq_a;
    logic [dtwm_pkg::PAT_W-1:0] w_eq_b;

    always_comb begin
        for (int k = 0; k < dtwm_pkg::WIN; k++) begin
            for (int j = 0; j < dtwm_pkg::WIN - 1; j++) begin
                n_win[k][j] = r_win[k][j+1];
            end
            n_win[k][dtwm_pkg::WIN-1] = i_col[k];
        end
        for (int k = 0; k < dtwm_pkg::WIN; k++) begin
            for (int j = 0; j < dtwm_pkg::WIN; j++) begin
                w_eq_a[k*dtwm_pkg::WIN+j] =
                    (r_win[k][j] == dtwm_pkg::PIXEL_BITS'(i_pat_a[k*dtwm_pkg::WIN+j]));
                w_eq_b[k*dtwm_pkg::WIN+j] =
                    (r_win[k][j] == dtwm_pkg::PIXEL_BITS'(i_pat_b[k*dtwm_pkg::WIN+j]));
            end
        end
    end

    assign o_hit_a = &w_eq_a;
    assign o_hit_b = &w_eq_b;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= n_win;
        end
    end

endmodule

/* rtl/core/dtwm_match_map.sv */
// Template A match map: row-wide memory with per-row valid bits for frame clears.
// Marks A hits, looks up the transposed place for B hits; uses dtwm_pkg.
module dtwm_match_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  dtwm_pkg::t_map_req  i_req,
    output logic                o_pair
);

    logic [dtwm_pkg::MAP_W-1:0] r_map [dtwm_pkg::MAP_H];
    logic [dtwm_pkg::MAP_H-1:0] r_rowv;
    logic [dtwm_pkg::MAP_H-1:0] n_rowv;
    logic [dtwm_pkg::MAP_H-1:0] w_veff;
    logic [dtwm_pkg::MAP_W-1:0] r_q;
    logic                       r_look;
    logic                       r_fwd;
    logic                       r_qv;
    logic [dtwm_pkg::MAP_CW-1:0] r_bit;
    logic [dtwm_pkg::MAP_RW-1:0] w_wrow;
    logic [dtwm_pkg::MAP_CW-1:0] w_wbit;
    logic [dtwm_pkg::MAP_RW-1:0] w_rrow;
    logic [dtwm_pkg::MAP_CW-1:0] w_rbit;
    logic                       w_wr_ok;
    logic                       w_rd_ok;
    logic                       w_rowv_rd;

    always_comb begin
        w_veff  = i_req.clr_pre ? '0 : r_rowv;
        w_wrow  = i_req.tr[dtwm_pkg::MAP_RW-1:0];
        w_wbit  = i_req.tc[dtwm_pkg::MAP_CW-1:0];
        w_rrow  = i_req.tc[dtwm_pkg::MAP_RW-1:0];
        w_rbit  = i_req.tr[dtwm_pkg::MAP_CW-1:0];
        w_wr_ok = i_req.fire && i_req.mark
                  && (int'(i_req.tr) < dtwm_pkg::MAP_H) && (int'(i_req.tc) < dtwm_pkg::MAP_W);
        w_rd_ok = i_req.fire && i_req.look
                  && (int'(i_req.tc) < dtwm_pkg::MAP_H) && (int'(i_req.tr) < dtwm_pkg::MAP_W);
        w_rowv_rd = 1'b0;
        if (w_rd_ok) begin
            w_rowv_rd = w_veff[w_rrow];
        end
        n_rowv = w_veff;
        if (w_wr_ok) begin
            n_rowv[w_wrow] = 1'b1;
        end
        if (i_req.clr_post) begin
            n_rowv = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            if (w_veff[w_wrow]) begin
                r_map[w_wrow][w_wbit] <= 1'b1;
            end else begin
                r_map[w_wrow] <= dtwm_pkg::MAP_W'(1) << w_wbit;
            end
        end
        if (w_rd_ok) begin
            r_q <= r_map[w_rrow];
        end
        if (i_adv) begin
            r_bit <= w_rbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rowv <= '0;
            r_look <= 1'b0;
            r_fwd  <= 1'b0;
            r_qv   <= 1'b0;
        end else begin
            if (i_req.fire) begin
                r_rowv <= n_rowv;
            end
            if (i_adv) begin
                r_look <= w_rd_ok;
                r_fwd  <= w_rd_ok && w_wr_ok && (i_req.tc == i_req.tr);
                r_qv   <= w_rowv_rd;
            end
        end
    end

    assign o_pair = r_look && (r_fwd || (r_qv && r_q[r_bit]));

endmodule

/* rtl/core/dual_template_window_matcher.sv */
// Path: a result passes stages s1, s2 and s3, then the output register behind o_m_tvalid.
// Throughput: one pixel per cycle, set by one read and one write per cycle on the
// line and match map memories; the output skid absorbs one stall, then input waits.
// Reset (synchronous, active low) clears counters, the line and map valid bits and
// the pipeline, and restores width/height 15 and both templates; no clearing pass.
module dual_template_window_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dtwm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dtwm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [dtwm_pkg::TDATA_IN_W-1:0]     i_s_tdata,  // pixel_value
    input  logic [dtwm_pkg::TUSER_IN_W-1:0]     i_s_tuser,  // frame_start
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [dtwm_pkg::TDATA_OUT_W-1:0]    o_m_tdata,  // window_col, window_row
    output logic [dtwm_pkg::TUSER_OUT_W-1:0]    o_m_tuser   // hit_a, hit_b, pair_found
);

    dtwm_pkg::t_size r_width;
    dtwm_pkg::t_size r_height;
    dtwm_pkg::t_pat  r_pat_a;
    dtwm_pkg::t_pat  r_pat_b;
    dtwm_pkg::t_col  r_col;
    dtwm_pkg::t_row  r_row;

    logic            w_en;
    logic            w_accept;
    logic            w_fs;
    dtwm_pkg::t_col  w_c;
    dtwm_pkg::t_row  w_r;
    dtwm_pkg::t_size w_w;
    dtwm_pkg::t_size w_h;
    logic            w_wrap;
    logic            w_last_row;
    logic            w_win_ok;

    logic            r_s1_v;
    dtwm_pkg::t_pix  r_s1_pix;
    dtwm_pkg::t_col  r_s1_c;
    logic            r_s1_win;
    logic            r_s1_fs;
    logic            r_s1_eof;
    dtwm_pkg::t_pos  r_s1_tc;
    dtwm_pkg::t_pos  r_s1_tr;

    logic            r_s2_v;
    logic            r_s2_win;
    logic            r_s2_fs;
    logic            r_s2_eof;
    dtwm_pkg::t_pos  r_s2_tc;
    dtwm_pkg::t_pos  r_s2_tr;

    logic            r_s3_v;
    logic            r_s3_ha;
    logic            r_s3_hb;
    dtwm_pkg::t_pos  r_s3_tc;
    dtwm_pkg::t_pos  r_s3_tr;

    dtwm_pkg::t_wcol    w_col;
    logic               w_hit_a;
    logic               w_hit_b;
    logic               w_ha;
    logic               w_hb;
    dtwm_pkg::t_map_req w_req;
    logic               w_pair;

    logic                               w_res_v;
    logic [dtwm_pkg::TDATA_OUT_W-1:0]   w_res_data;
    logic [dtwm_pkg::TUSER_OUT_W-1:0]   w_res_user;
    logic                               w_out_fire;
    logic                               r_ov;
    logic [dtwm_pkg::TDATA_OUT_W-1:0]   r_od_data;
    logic [dtwm_pkg::TUSER_OUT_W-1:0]   r_od_user;
    logic                               r_sk_v;
    logic [dtwm_pkg::TDATA_OUT_W-1:0]   r_sk_data;
    logic [dtwm_pkg::TUSER_OUT_W-1:0]   r_sk_user;

    assign o_cfg_ready = 1'b1;
    assign w_en        = ~r_sk_v;
    assign o_s_tready  = w_en;
    assign w_accept    = i_s_tvalid & w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dtwm_pkg::RST_SIZE;
            r_height <= dtwm_pkg::RST_SIZE;
            r_pat_a  <= dtwm_pkg::RST_PATTERN;
            r_pat_b  <= dtwm_pkg::RST_PATTERN;
        end else if (i_cfg_valid) begin
            unique case (dtwm_pkg::t_cfg_idx'(i_cfg_addr))
                dtwm_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[dtwm_pkg::SIZE_W-1:0];
                dtwm_pkg::CFG_HEIGHT: r_height <= i_cfg_data[dtwm_pkg::SIZE_W-1:0];
                dtwm_pkg::CFG_PAT_A:  r_pat_a  <= i_cfg_data[dtwm_pkg::PAT_W-1:0];
                dtwm_pkg::CFG_PAT_B:  r_pat_b  <= i_cfg_data[dtwm_pkg::PAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_fs       = i_s_tuser[0];
        w_c        = w_fs ? '0 : r_col;
        w_r        = w_fs ? '0 : r_row;
        w_w        = dtwm_pkg::clamp_size(r_width, dtwm_pkg::SIZE_W'(dtwm_pkg::MAX_WIDTH));
        w_h        = dtwm_pkg::clamp_size(r_height, dtwm_pkg::SIZE_W'(dtwm_pkg::MAX_HEIGHT));
        w_wrap     = (dtwm_pkg::SIZE_W'(w_c) + dtwm_pkg::SIZE_W'(1)) >= w_w;
        w_last_row = (dtwm_pkg::SIZE_W'(w_r) + dtwm_pkg::SIZE_W'(1)) >= w_h;
        w_win_ok   = (w_c >= dtwm_pkg::COL_W'(dtwm_pkg::LINES))
                     && (w_r >= dtwm_pkg::ROW_W'(dtwm_pkg::LINES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_wrap) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : (w_r + dtwm_pkg::ROW_W'(1));
                end else begin
                    r_col <= w_c + dtwm_pkg::COL_W'(1);
                    r_row <= w_r;
                end
            end
            if (w_en) begin
                r_s1_v <= w_accept;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix <= i_s_tdata[dtwm_pkg::PIXEL_BITS-1:0];
            r_s1_c   <= w_c;
            r_s1_win <= w_win_ok;
            r_s1_fs  <= w_fs;
            r_s1_eof <= w_wrap && w_last_row;
            r_s1_tc  <= dtwm_pkg::POS_W'(w_c) - dtwm_pkg::POS_W'(dtwm_pkg::LINES);
            r_s1_tr  <= dtwm_pkg::POS_W'(w_r) - dtwm_pkg::POS_W'(dtwm_pkg::LINES);
        end
        if (w_en) begin
            r_s2_win <= r_s1_win;
            r_s2_fs  <= r_s1_fs;
            r_s2_eof <= r_s1_eof;
            r_s2_tc  <= r_s1_tc;
            r_s2_tr  <= r_s1_tr;
            r_s3_ha  <= w_ha;
            r_s3_hb  <= w_hb;
            r_s3_tc  <= r_s2_tc;
            r_s3_tr  <= r_s2_tr;
        end
    end

    dtwm_line_buf u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_en),
        .i_rd_en  (w_accept),
        .i_rd_col (w_c),
        .i_wr_en  (w_en & r_s1_v),
        .i_wr_col (r_s1_c),
        .i_pix    (r_s1_pix),
        .o_col    (w_col)
    );

    dtwm_window u_win (
        .i_clk   (i_clk),
        .i_shift (w_en & r_s1_v),
        .i_col   (w_col),
        .i_pat_a (r_pat_a),
        .i_pat_b (r_pat_b),
        .o_hit_a (w_hit_a),
        .o_hit_b (w_hit_b)
    );

    always_comb begin
        w_ha           = r_s2_v && r_s2_win && w_hit_a;
        w_hb           = r_s2_v && r_s2_win && w_hit_b;
        w_req.fire     = w_en & r_s2_v;
        w_req.clr_pre  = r_s2_fs;
        w_req.clr_post = r_s2_eof;
        w_req.mark     = w_ha && (r_s2_tc >= r_s2_tr);
        w_req.look     = w_hb && (r_s2_tc <= r_s2_tr);
        w_req.tc       = r_s2_tc;
        w_req.tr       = r_s2_tr;
    end

    dtwm_match_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_en),
        .i_req   (w_req),
        .o_pair  (w_pair)
    );

    always_comb begin
        w_res_v    = r_s3_v && (r_s3_ha || r_s3_hb);
        w_res_data = dtwm_pkg::TDATA_OUT_W'({dtwm_pkg::OUT_W'(r_s3_tr),
                                             dtwm_pkg::OUT_W'(r_s3_tc)});
        w_res_user = {w_pair, r_s3_hb, r_s3_ha};
        w_out_fire = r_ov & i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else begin
            if (w_en && w_res_v) begin
                if (!r_ov || w_out_fire) begin
                    r_ov <= 1'b1;
                end else begin
                    r_sk_v <= 1'b1;
                end
            end else if (r_sk_v && w_out_fire) begin
                r_sk_v <= 1'b0;
                r_ov   <= 1'b1;
            end else if (w_out_fire) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_res_v) begin
            if (!r_ov || w_out_fire) begin
                r_od_data <= w_res_data;
                r_od_user <= w_res_user;
            end else begin
                r_sk_data <= w_res_data;
                r_sk_user <= w_res_user;
            end
        end else if (r_sk_v && w_out_fire) begin
            r_od_data <= r_sk_data;
            r_od_user <= r_sk_user;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od_data;
    assign o_m_tuser  = r_od_user;

endmodule

/* rtl/core/dtwm_checker.sv */
// Port-level checks on the matcher's result stream, and the bind that attaches them.
// Uses dtwm_pkg; bound to dual_template_window_matcher.
module dtwm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [dtwm_pkg::TDATA_OUT_W-1:0]   o_m_tdata,
    input logic [dtwm_pkg::TUSER_OUT_W-1:0]   o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] || o_m_tuser[1]))
        else $error("result without a template hit");

    a_pair_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tuser[1] && (o_m_tdata[5:0] <= o_m_tdata[11:6]))
        else $error("pair without B hit on or below the diagonal");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[5:0] < 6'd60) && (o_m_tdata[11:6] < 6'd60)
                       && (o_m_tdata[15:12] == 4'd0))
        else $error("window position out of range");

endmodule

bind dual_template_window_matcher dtwm_checker u_dtwm_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for dual_template_window_matcher: streams stamped frames (binary or noisy) of varied size,
// predicts every template hit and pairing in a scoreboard class, and checks each result transfer.
// Depends on dtwm_pkg and the dual_template_window_matcher RTL.
module tb_top;
    import dtwm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TARGET_PIXELS  = 1450;
    localparam t_pat ALL_ONES     = '1;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } t_ready_mode;

    typedef enum logic [1:0] {
        FRAME_CLEAN,
        FRAME_CUT,
        FRAME_NOISE,
        FRAME_RESUME
    } t_frame_kind;

    typedef struct packed {
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
        logic             hit_a;
        logic             hit_b;
        logic             pair;
    } t_window_hit;

    class window_match_scoreboard;
        t_size       width_reg;
        t_size       height_reg;
        t_pat        pat_a;
        t_pat        pat_b;
        t_pix        line_mem [LINES][MAX_WIDTH];
        t_pix        win_px [WIN][WIN];
        int unsigned col_pos;
        int unsigned row_pos;
        bit          a_marks [MAP_H][MAP_W];
        t_window_hit expected_hits [$];
        int          mismatch_count;

        function new();
            width_reg  = RST_SIZE;
            height_reg = RST_SIZE;
            pat_a      = RST_PATTERN;
            pat_b      = RST_PATTERN;
            foreach (line_mem[k, j]) line_mem[k][j] = '0;
            foreach (win_px[k, j]) win_px[k][j] = '0;
            col_pos = 0;
            row_pos = 0;
            clear_marks();
            mismatch_count = 0;
        endfunction

        function void clear_marks();
            foreach (a_marks[k, j]) a_marks[k][j] = 1'b0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_pat value);
            case (idx)
                CFG_WIDTH:  width_reg  = value[SIZE_W-1:0];
                CFG_HEIGHT: height_reg = value[SIZE_W-1:0];
                CFG_PAT_A:  pat_a      = value;
                CFG_PAT_B:  pat_b      = value;
                default: ;
            endcase
        endfunction

        function bit window_is(t_pat pat);
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    if (win_px[r][c] != t_pix'(pat[r*WIN+c])) return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_pixel(t_pix pix, logic sof);
            int unsigned w, h, c, r, tc, tr;
            bit          ha, hb, pr;
            t_window_hit hit;
            w  = (width_reg < WIN) ? WIN : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            h  = (height_reg < WIN) ? WIN : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
            ha = 1'b0;
            hb = 1'b0;
            pr = 1'b0;
            if (sof) begin
                col_pos = 0;
                row_pos = 0;
                clear_marks();
            end
            c = col_pos;
            r = row_pos;
            if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
            for (int k = 0; k < WIN; k++) begin
                for (int j = 0; j < WIN - 1; j++) win_px[k][j] = win_px[k][j+1];
            end
            for (int k = 0; k < LINES; k++) win_px[k][WIN-1] = line_mem[k][c];
            win_px[WIN-1][WIN-1] = pix;
            for (int k = 0; k < LINES - 1; k++) line_mem[k][c] = line_mem[k+1][c];
            line_mem[LINES-1][c] = pix;
            if (r >= LINES && c >= LINES) begin
                tc = c - LINES;
                tr = r - LINES;
                ha = window_is(pat_a);
                hb = window_is(pat_b);
                if (ha && tc >= tr && tr < MAP_H && tc < MAP_W) a_marks[tr][tc] = 1'b1;
                if (hb && tc <= tr && tc < MAP_H && tr < MAP_W) pr = a_marks[tc][tr];
                if (ha || hb) begin
                    hit.col   = OUT_W'(tc);
                    hit.row   = OUT_W'(tr);
                    hit.hit_a = ha;
                    hit.hit_b = hb;
                    hit.pair  = pr;
                    expected_hits.push_back(hit);
                end
            end
            if (c + 1 >= w) begin
                col_pos = 0;
                if (r + 1 >= h) begin
                    row_pos = 0;
                    clear_marks();
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void check_result(logic [TDATA_OUT_W-1:0] data, logic [TUSER_OUT_W-1:0] user);
            t_window_hit want, got;
            got.col   = data[OUT_W-1:0];
            got.row   = data[2*OUT_W-1:OUT_W];
            got.hit_a = user[0];
            got.hit_b = user[1];
            got.pair  = user[2];
            if (expected_hits.size() == 0) begin
                $error("unexpected result transfer: col %0d row %0d", got.col, got.row);
                mismatch_count++;
                return;
            end
            want = expected_hits.pop_front();
            if (got.col !== want.col) begin
                $error("window_col: expected %0d, got %0d", want.col, got.col);
                mismatch_count++;
            end
            if (got.row !== want.row) begin
                $error("window_row: expected %0d, got %0d", want.row, got.row);
                mismatch_count++;
            end
            if (got.hit_a !== want.hit_a) begin
                $error("hit_a: expected %0d, got %0d", want.hit_a, got.hit_a);
                mismatch_count++;
            end
            if (got.hit_b !== want.hit_b) begin
                $error("hit_b: expected %0d, got %0d", want.hit_b, got.hit_b);
                mismatch_count++;
            end
            if (got.pair !== want.pair) begin
                $error("pair_found: expected %0d, got %0d", want.pair, got.pair);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [TDATA_IN_W-1:0]  i_s_tdata   = '0;  // pixel_value
    logic [TUSER_IN_W-1:0]  i_s_tuser   = '0;  // frame_start
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_tdata;         // window_col, window_row
    logic [TUSER_OUT_W-1:0] o_m_tuser;         // hit_a, hit_b, pair_found

    window_match_scoreboard scoreboard;
    t_pix                   canvas [MAX_HEIGHT][MAX_WIDTH];
    int unsigned            pixels_sent = 0;
    int unsigned            burst_left  = 0;
    int unsigned            quiet_cycles = 0;
    int unsigned            tick = 0;
    int unsigned            mode_left = 0;
    t_ready_mode            ready_mode = READY_ALWAYS;
    int unsigned            cur_w, cur_h;
    t_pat                   cur_pat_a, cur_pat_b;

    always #4 i_clk = ~i_clk;

    dual_template_window_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) scoreboard.write_reg(t_cfg_idx'(i_cfg_addr), i_cfg_data);
            if (i_s_tvalid && o_s_tready) scoreboard.note_pixel(i_s_tdata[PIXEL_BITS-1:0], i_s_tuser[0]);
            if (o_m_tvalid && i_m_tready) scoreboard.check_result(o_m_tdata, o_m_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_s_tvalid && o_s_tready) ||
            (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dual_template_window_matcher test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        tick <= tick + 1;
        if (mode_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 160);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: i_m_tready <= 1'b1;
            READY_MOSTLY: i_m_tready <= ($urandom_range(0, 4) != 0);
            READY_RARELY: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:      i_m_tready <= ((tick % 7) < 3);
        endcase
    end

    task automatic write_cfg(input t_cfg_idx idx, input t_pat value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pix pix, input logic sof);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_IN_W'(pix);
        i_s_tuser  <= sof;
        do @(posedge i_clk); while (!o_s_tready);
        pixels_sent++;
    endtask

    // hold off until every expected transfer is out, then let the pipeline settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic stamp(input t_pat pat, input int unsigned tr, input int unsigned tc);
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) canvas[tr+i][tc+j] = t_pix'(pat[i*WIN+j]);
        end
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h, input t_frame_kind kind);
        int unsigned bg, stamps, tc, tr, span, limit, noise_pct;
        t_pix        pix;
        bg     = $urandom_range(0, 3);
        span   = ((w < h) ? w : h) - WIN;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                canvas[y][x] = (bg == 0) ? t_pix'(0) : (bg == 1) ? t_pix'(1) :
                               t_pix'($urandom_range(0, 1));
            end
        end
        stamps = $urandom_range(1, 4);
        repeat (stamps) begin
            tr = $urandom_range(0, span);
            tc = $urandom_range(tr, w - WIN);
            // B goes to the transposed place so that it can pair with A
            if ($urandom_range(0, 3) == 0) begin
                if (tc + WIN <= h) stamp(cur_pat_b, tc, tr);
                stamp(cur_pat_a, tr, tc);
            end else begin
                stamp(cur_pat_a, tr, tc);
                if (tc + WIN <= h && $urandom_range(0, 4) != 0) stamp(cur_pat_b, tc, tr);
            end
        end
        noise_pct = (kind == FRAME_NOISE) ? 100 : ($urandom_range(0, 3) == 0) ? 4 : 0;
        limit = (kind == FRAME_CUT) ? $urandom_range(1, w * h - 1) : w * h;
        if (pixels_sent + limit > TARGET_PIXELS) begin
            limit = (pixels_sent < TARGET_PIXELS) ? TARGET_PIXELS - pixels_sent : 0;
        end
        for (int n = 0; n < limit; n++) begin
            pix = ($urandom_range(0, 99) < noise_pct) ? t_pix'($urandom) : canvas[n / w][n % w];
            send_pixel(pix, (n == 0) && (kind != FRAME_RESUME));
        end
    endtask

    task automatic pick_config(input int unsigned phase);
        int unsigned wr, hr, pick;
        if (phase % 9 == 4) begin
            wr = $urandom_range(0, 1) ? MAX_WIDTH : 127;
            hr = $urandom_range(0, 5);
        end else if (phase % 9 == 7) begin
            wr = $urandom_range(0, 5);
            hr = $urandom_range(0, 1) ? MAX_HEIGHT : 127;
        end else begin
            wr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
            hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
        end
        write_cfg(CFG_WIDTH, t_pat'(wr));
        write_cfg(CFG_HEIGHT, t_pat'(hr));
        cur_w = (wr < WIN) ? WIN : (wr > MAX_WIDTH) ? MAX_WIDTH : wr;
        cur_h = (hr < WIN) ? WIN : (hr > MAX_HEIGHT) ? MAX_HEIGHT : hr;
        if ($urandom_range(0, 4) < 3) begin
            pick = $urandom_range(0, 7);
            cur_pat_a = (pick == 0) ? t_pat'(0) : (pick == 1) ? ALL_ONES : t_pat'($urandom);
            write_cfg(CFG_PAT_A, cur_pat_a);
        end
        if ($urandom_range(0, 4) < 3) begin
            pick = $urandom_range(0, 7);
            cur_pat_b = (pick == 0) ? cur_pat_a : (pick == 1) ? ALL_ONES :
                        (pick == 2) ? t_pat'(0) : t_pat'($urandom);
            write_cfg(CFG_PAT_B, cur_pat_b);
        end
    endtask

    initial begin
        int unsigned phase, frames;
        t_frame_kind kind;
        scoreboard = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // undersized frame, both templates blank: both hit at the diagonal origin and pair
        write_cfg(CFG_WIDTH, t_pat'(4));
        write_cfg(CFG_HEIGHT, t_pat'(0));
        write_cfg(CFG_PAT_A, t_pat'(0));
        write_cfg(CFG_PAT_B, t_pat'(0));
        cur_w = WIN;
        cur_h = WIN;
        cur_pat_a = '0;
        cur_pat_b = '0;
        for (int n = 0; n < WIN * WIN; n++) send_pixel(t_pix'(0), n == 0);
        wait_idle();

        phase = 0;
        while (pixels_sent < TARGET_PIXELS) begin
            pick_config(phase);
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames && pixels_sent < TARGET_PIXELS; f++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:  kind = FRAME_CUT;
                    3, 4:     kind = FRAME_NOISE;
                    5, 6, 7:  kind = (f == 0) ? FRAME_RESUME : FRAME_CLEAN;
                    default:  kind = FRAME_CLEAN;
                endcase
                send_frame(cur_w, cur_h, kind);
            end
            wait_idle();
            phase++;
        end

        if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0) begin
            $display("dual_template_window_matcher test passed");
        end else begin
            $display("dual_template_window_matcher test failed");
        end
        $finish;
    end

endmodule
